// ----- rtl/color_mask_closing_macros.svh -----
// Assertion macros shared by the color mask closing RTL.
// No dependencies; included by files that carry assertions.
`ifndef COLOR_MASK_CLOSING_MACROS_SVH
`define COLOR_MASK_CLOSING_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cmc_pkg.sv -----
// Shared constants and types for the color mask closing block.
// No dependencies; used by every module under rtl but cmc_ram.
package cmc_pkg;

   localparam int RADIUS     = 5;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // window geometry
   localparam int SPAN  = 2 * RADIUS + 1;
   localparam int VEC_W = 2 * RADIUS;
   localparam int TAG_W = $clog2(SPAN);

   // field and counter widths
   localparam int CH_W   = 8;
   localparam int DIM_W  = 11;
   localparam int OUT_W  = 10;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2 * RADIUS + 2);
   localparam int STEP_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * (RADIUS * MAX_WIDTH + RADIUS) + 1);

   // result queue
   localparam int Q_DEPTH = 16;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int PEND_W  = $clog2(Q_DEPTH + 1);

   // configuration register indexes
   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] REG_LOW_BLUE     = 3'd0;
   localparam logic [IDX_W-1:0] REG_LOW_GREEN    = 3'd1;
   localparam logic [IDX_W-1:0] REG_LOW_RED      = 3'd2;
   localparam logic [IDX_W-1:0] REG_HIGH_BLUE    = 3'd3;
   localparam logic [IDX_W-1:0] REG_HIGH_GREEN   = 3'd4;
   localparam logic [IDX_W-1:0] REG_HIGH_RED     = 3'd5;
   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
   localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd640;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd480;

   // commands
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // one cell of the horizontal window chain
   typedef struct packed {
      logic             val;
      logic [TAG_W-1:0] tag;
   } cell_type;

   // step information that rides along with each word
   typedef struct packed {
      logic             act1;
      logic             first1;
      logic             emit;
      logic             last;
      logic [OUT_W-1:0] row;
      logic [OUT_W-1:0] col;
   } side_type;

   // one entry of the result queue
   typedef struct packed {
      logic             closed;
      logic [OUT_W-1:0] row;
      logic [OUT_W-1:0] col;
      logic             last;
   } rsp_type;

endpackage

// ----- rtl/cmc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies. Read during write to the same address returns old data.
module cmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cmc_cell.sv -----
// One cell of the horizontal window chain: holds a column value and its row tag.
// Depends on cmc_pkg.
module cmc_cell (
   input  logic                      clock,
   input  logic                      shift_en,
   input  logic                      erode,
   input  cmc_pkg::cell_type         in_cell,
   input  logic [cmc_pkg::TAG_W-1:0] center_tag,
   output cmc_pkg::cell_type         out_cell,
   output logic                      term
);

   cmc_pkg::cell_type cell_ff;

   // take the neighbor's value on every step
   always_ff @(posedge clock) begin
      if (shift_en) begin
         cell_ff <= in_cell;
      end
   end

   // a column from another row lies outside the frame: neutral value
   assign term     = (cell_ff.tag == center_tag) ? cell_ff.val : erode;
   assign out_cell = cell_ff;

endmodule

// ----- rtl/cmc_window.sv -----
// Square window stage: vertical reduce through a column line store, then
// horizontal reduce over a chain of cells. OR for dilation, AND for erosion.
// Depends on cmc_pkg, cmc_ram and cmc_cell.
module cmc_window (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      erode,
   input  logic                      in_vld,
   input  logic                      in_first,
   input  logic                      in_bit,
   input  cmc_pkg::side_type         in_side,
   input  logic [cmc_pkg::DIM_W-1:0] frame_w,
   input  logic [cmc_pkg::DIM_W-1:0] frame_h,
   output logic                      out_vld,
   output logic                      out_bit,
   output cmc_pkg::side_type         out_side
);

   localparam int MW = cmc_pkg::ROW_W + 1;

   // position counters of the incoming word
   logic [cmc_pkg::ROW_W-1:0] ur_ff, ur_in, ur_now;
   logic [cmc_pkg::COL_W-1:0] uc_ff, uc_in, uc_now;
   logic                      col_last;
   logic [cmc_pkg::SPAN-1:0]  vmask;

   // stage 1 registers
   logic                      s1_vld_ff;
   logic                      s1_bit_ff;
   logic [cmc_pkg::SPAN-1:0]  s1_mask_ff;
   logic [cmc_pkg::TAG_W-1:0] s1_tag_ff;
   logic [cmc_pkg::COL_W-1:0] s1_col_ff;
   cmc_pkg::side_type         s1_side_ff;

   // line store write tracking for forwarding
   logic                      wr_vld_ff;
   logic [cmc_pkg::COL_W-1:0] wr_col_ff;
   logic [cmc_pkg::VEC_W-1:0] wr_vec_ff;
   logic [cmc_pkg::VEC_W-1:0] ram_rdata, rvec, wvec;
   logic [cmc_pkg::SPAN-1:0]  full_col, col_terms;
   logic                      col_val;

   // cell chain
   cmc_pkg::cell_type         chain_in [cmc_pkg::SPAN];
   cmc_pkg::cell_type         chain_out [cmc_pkg::SPAN];
   logic [cmc_pkg::SPAN-1:0]  row_terms;
   logic                      win_val;

   // stage 2 and output registers
   logic                      s2_vld_ff;
   cmc_pkg::side_type         s2_side_ff;
   logic                      out_vld_ff;
   logic                      out_bit_ff;
   cmc_pkg::side_type         out_side_ff;

   // stage 0: position of this word and its row validity
   assign ur_now   = in_first ? '0 : ur_ff;
   assign uc_now   = in_first ? '0 : uc_ff;
   assign col_last = ({1'b0, uc_now} + cmc_pkg::DIM_W'(1)) == frame_w;

   always_comb begin
      ur_in = ur_ff;
      uc_in = uc_ff;
      if (in_vld) begin
         uc_in = col_last ? '0 : uc_now + cmc_pkg::COL_W'(1);
         ur_in = col_last ? ur_now + cmc_pkg::ROW_W'(1) : ur_now;
      end
   end

   // bit k of the column is row ur_now - k; keep rows inside the frame
   always_comb begin
      for (int k = 0; k < cmc_pkg::SPAN; k++) begin
         vmask[k] = ({1'b0, ur_now} >= MW'(k)) &&
                    ({1'b0, ur_now} < (MW'(frame_h) + MW'(k)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ur_ff     <= '0;
         uc_ff     <= '0;
         s1_vld_ff <= 1'b0;
         wr_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         ur_ff     <= ur_in;
         uc_ff     <= uc_in;
         s1_vld_ff <= in_vld;
         wr_vld_ff <= s1_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         out_vld_ff <= s2_vld_ff;
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      s1_bit_ff   <= in_bit;
      s1_mask_ff  <= vmask;
      s1_tag_ff   <= ur_now[cmc_pkg::TAG_W-1:0];
      s1_col_ff   <= uc_now;
      s1_side_ff  <= in_side;
      wr_col_ff   <= s1_col_ff;
      wr_vec_ff   <= wvec;
      s2_side_ff  <= s1_side_ff;
      out_bit_ff  <= win_val;
      out_side_ff <= s2_side_ff;
   end

   // column line store: previous rows of each column, shifted per visit
   cmc_ram #(
      .WIDTH (cmc_pkg::VEC_W),
      .DEPTH (cmc_pkg::MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wvec),
      .rd_addr (uc_now),
      .rd_data (ram_rdata)
   );

   // stage 1: forward a write to the same column made in the previous cycle
   assign rvec      = (wr_vld_ff && (wr_col_ff == s1_col_ff)) ? wr_vec_ff : ram_rdata;
   assign wvec      = {rvec[cmc_pkg::VEC_W-2:0], s1_bit_ff};
   assign full_col  = {rvec, s1_bit_ff};
   assign col_terms = (full_col & s1_mask_ff) | (~s1_mask_ff & {cmc_pkg::SPAN{erode}});
   assign col_val   = erode ? (&col_terms) : (|col_terms);

   // horizontal chain of cells, newest column in cell 0
   genvar j;
   generate
      for (j = 0; j < cmc_pkg::SPAN; j++) begin : g_cell
         if (j == 0) begin : g_head
            assign chain_in[j] = '{val: col_val, tag: s1_tag_ff};
         end else begin : g_link
            assign chain_in[j] = chain_out[j-1];
         end
         cmc_cell u_cell (
            .clock      (clock),
            .shift_en   (s1_vld_ff),
            .erode      (erode),
            .in_cell    (chain_in[j]),
            .center_tag (chain_out[cmc_pkg::RADIUS].tag),
            .out_cell   (chain_out[j]),
            .term       (row_terms[j])
         );
      end
   endgenerate

   // stage 2: reduce across the row
   assign win_val = erode ? (&row_terms) : (|row_terms);

   assign out_vld  = out_vld_ff;
   assign out_bit  = out_bit_ff;
   assign out_side = out_side_ff;

endmodule

// ----- rtl/color_mask_closing.sv -----
// color_mask_closing: color threshold followed by a square closing (dilate, erode).
// Input channel (req_*): one word per pixel in raster order, command 0. After
// the last pixel, drain words (command 1) push the remaining mask bits out;
// a drain while idle or before all pixels arrived is taken and dropped.
// The first pixel of a frame latches frame_width and frame_height.
// Result channel (rsp_*): one closed-mask bit per pixel, in raster order, with
// row, column and frame_last on the final bit; the block is then idle.
// The result for pixel (r, c) is due on the step RADIUS*W + RADIUS pixel
// positions later, twice over (dilate, then erode), counting pixels and drains.
// Results reach rsp_valid through the input register, both windows and the queue.
// Throughput: one word per cycle while req_stall is low. Each window stage has
// one line store read and write per cycle; 2*RADIUS+1 cells shift once per word.
// A 16-entry result queue sits on the output; req_stall rises while the queue
// plus the words in flight that produce a result would fill it, so a stalled
// receiver backs up into req_stall without losing anything.
// Reset (synchronous) clears control state and loads register defaults; the
// line stores need no clearing since stale rows lie outside each new frame.
// The user must make configuration writes (csr_*) while idle; nothing checks it.
// Depends on cmc_pkg, cmc_window, cmc_cell, cmc_ram and the macro header.
`include "color_mask_closing_macros.svh"

module color_mask_closing (
   input  logic                      clock,
   input  logic                      reset,
   // input words
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [cmc_pkg::CH_W-1:0]  req_blue,
   input  logic [cmc_pkg::CH_W-1:0]  req_green,
   input  logic [cmc_pkg::CH_W-1:0]  req_red,
   // result words
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_closed_bit,
   output logic [cmc_pkg::OUT_W-1:0] rsp_out_row,
   output logic [cmc_pkg::OUT_W-1:0] rsp_out_column,
   output logic                      rsp_frame_last,
   // configuration
   input  logic                      csr_write,
   input  logic [cmc_pkg::IDX_W-1:0] csr_index,
   input  logic [cmc_pkg::DIM_W-1:0] csr_data
);

   localparam int SW = cmc_pkg::STEP_W;

   // configuration registers
   logic [cmc_pkg::CH_W-1:0]  low_blue_ff, low_green_ff, low_red_ff;
   logic [cmc_pkg::CH_W-1:0]  high_blue_ff, high_green_ff, high_red_ff;
   logic [cmc_pkg::DIM_W-1:0] frame_width_ff, frame_height_ff;

   // frame control
   logic                      busy_ff;
   logic [SW-1:0]             t_ff;
   logic [SW-1:0]             n_ff, lag_ff, lag2_ff, end_m1_ff;
   logic [cmc_pkg::DIM_W-1:0] cur_w_ff, cur_h_ff;
   logic [cmc_pkg::DIM_W-1:0] ew1_ff, ew2_ff, ew3_ff, eh1_ff, eh2_ff, eh3_ff;
   logic [cmc_pkg::DIM_W-1:0] w_clamp, h_clamp;
   logic [SW-1:0]             n_new, lag_new;
   logic [cmc_pkg::OUT_W-1:0] orow_ff, ocol_ff;
   logic                      acc, start, step, pix_left;
   logic                      act1, first1, emit, last, hit;
   cmc_pkg::side_type         side;

   // window stage 0 inputs
   logic                      w0_vld_ff, w0_first_ff, w0_bit_ff;
   cmc_pkg::side_type         w0_side_ff;
   logic                      w0_out_vld, w0_out_bit;
   cmc_pkg::side_type         w0_out_side;
   logic                      w1_out_vld, w1_out_bit;
   cmc_pkg::side_type         w1_out_side;

   // result queue
   cmc_pkg::rsp_type           q_mem_ff [cmc_pkg::Q_DEPTH];
   logic [cmc_pkg::Q_AW-1:0]   q_wr_ff, q_rd_ff;
   logic [cmc_pkg::PEND_W-1:0] q_cnt_ff, pend_ff;
   logic                       q_push, q_pop, pend_inc;
   cmc_pkg::rsp_type           q_head;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         low_blue_ff     <= '0;
         low_green_ff    <= '0;
         low_red_ff      <= '0;
         high_blue_ff    <= '1;
         high_green_ff   <= '1;
         high_red_ff     <= '1;
         frame_width_ff  <= cmc_pkg::RESET_WIDTH;
         frame_height_ff <= cmc_pkg::RESET_HEIGHT;
      end else if (csr_write) begin
         case (csr_index)
            cmc_pkg::REG_LOW_BLUE:     low_blue_ff     <= csr_data[cmc_pkg::CH_W-1:0];
            cmc_pkg::REG_LOW_GREEN:    low_green_ff    <= csr_data[cmc_pkg::CH_W-1:0];
            cmc_pkg::REG_LOW_RED:      low_red_ff      <= csr_data[cmc_pkg::CH_W-1:0];
            cmc_pkg::REG_HIGH_BLUE:    high_blue_ff    <= csr_data[cmc_pkg::CH_W-1:0];
            cmc_pkg::REG_HIGH_GREEN:   high_green_ff   <= csr_data[cmc_pkg::CH_W-1:0];
            cmc_pkg::REG_HIGH_RED:     high_red_ff     <= csr_data[cmc_pkg::CH_W-1:0];
            cmc_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            cmc_pkg::REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // frame size as used: zero reads as one, large sizes saturate
   assign w_clamp = (frame_width_ff == '0) ? cmc_pkg::DIM_W'(1) :
                    (frame_width_ff > cmc_pkg::DIM_W'(cmc_pkg::MAX_WIDTH)) ?
                    cmc_pkg::DIM_W'(cmc_pkg::MAX_WIDTH) : frame_width_ff;
   assign h_clamp = (frame_height_ff == '0) ? cmc_pkg::DIM_W'(1) :
                    (frame_height_ff > cmc_pkg::DIM_W'(cmc_pkg::MAX_HEIGHT)) ?
                    cmc_pkg::DIM_W'(cmc_pkg::MAX_HEIGHT) : frame_height_ff;
   assign n_new   = SW'(w_clamp) * SW'(h_clamp);
   assign lag_new = SW'(cmc_pkg::RADIUS) * SW'(w_clamp) + SW'(cmc_pkg::RADIUS);

   // step decode
   assign acc      = req_valid && !req_stall;
   assign start    = acc && !busy_ff && (req_command == cmc_pkg::CMD_PIXEL);
   assign pix_left = t_ff < n_ff;
   assign step     = start ||
                     (acc && busy_ff && !(pix_left && (req_command == cmc_pkg::CMD_DRAIN)));
   assign act1     = !start && (t_ff >= lag_ff);
   assign first1   = !start && (t_ff == lag_ff);
   assign emit     = !start && (t_ff >= lag2_ff) && (t_ff <= end_m1_ff);
   assign last     = t_ff == end_m1_ff;

   assign hit = (req_blue  >= low_blue_ff)  && (req_blue  <= high_blue_ff)  &&
                (req_green >= low_green_ff) && (req_green <= high_green_ff) &&
                (req_red   >= low_red_ff)   && (req_red   <= high_red_ff);

   assign side = '{act1: act1, first1: first1, emit: emit, last: last,
                   row: orow_ff, col: ocol_ff};

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         t_ff    <= '0;
         orow_ff <= '0;
         ocol_ff <= '0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            t_ff    <= SW'(1);
            orow_ff <= '0;
            ocol_ff <= '0;
         end else if (step) begin
            t_ff <= t_ff + SW'(1);
            if (emit) begin
               if (last) begin
                  busy_ff <= 1'b0;
               end
               if (({1'b0, ocol_ff} + cmc_pkg::DIM_W'(1)) == cur_w_ff) begin
                  ocol_ff <= '0;
                  orow_ff <= orow_ff + cmc_pkg::OUT_W'(1);
               end else begin
                  ocol_ff <= ocol_ff + cmc_pkg::OUT_W'(1);
               end
            end
         end
      end
   end

   // frame constants, latched by the first pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_w_ff  <= cmc_pkg::DIM_W'(1);
         cur_h_ff  <= cmc_pkg::DIM_W'(1);
         n_ff      <= SW'(1);
         lag_ff    <= '0;
         lag2_ff   <= '0;
         end_m1_ff <= '0;
      end else if (start) begin
         cur_w_ff  <= w_clamp;
         cur_h_ff  <= h_clamp;
         n_ff      <= n_new;
         lag_ff    <= lag_new;
         lag2_ff   <= lag_new + lag_new;
         end_m1_ff <= n_new + lag_new + lag_new - SW'(1);
      end
   end

   // frame size seen by the erosion stage, delayed by the dilation latency so
   // the tail of one frame keeps its size while the next frame starts
   always_ff @(posedge clock) begin
      if (reset) begin
         ew1_ff <= cmc_pkg::DIM_W'(1);
         ew2_ff <= cmc_pkg::DIM_W'(1);
         ew3_ff <= cmc_pkg::DIM_W'(1);
         eh1_ff <= cmc_pkg::DIM_W'(1);
         eh2_ff <= cmc_pkg::DIM_W'(1);
         eh3_ff <= cmc_pkg::DIM_W'(1);
      end else begin
         ew1_ff <= cur_w_ff;
         ew2_ff <= ew1_ff;
         ew3_ff <= ew2_ff;
         eh1_ff <= cur_h_ff;
         eh2_ff <= eh1_ff;
         eh3_ff <= eh2_ff;
      end
   end

   // register the step into the dilation stage
   always_ff @(posedge clock) begin
      if (reset) begin
         w0_vld_ff <= 1'b0;
      end else begin
         w0_vld_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      w0_first_ff <= start;
      w0_bit_ff   <= hit && (req_command == cmc_pkg::CMD_PIXEL);
      w0_side_ff  <= side;
   end

   // dilation of the raw mask
   cmc_window u_dilate (
      .clock    (clock),
      .reset    (reset),
      .erode    (1'b0),
      .in_vld   (w0_vld_ff),
      .in_first (w0_first_ff),
      .in_bit   (w0_bit_ff),
      .in_side  (w0_side_ff),
      .frame_w  (cur_w_ff),
      .frame_h  (cur_h_ff),
      .out_vld  (w0_out_vld),
      .out_bit  (w0_out_bit),
      .out_side (w0_out_side)
   );

   // erosion of the dilated mask
   cmc_window u_erode (
      .clock    (clock),
      .reset    (reset),
      .erode    (1'b1),
      .in_vld   (w0_out_vld && w0_out_side.act1),
      .in_first (w0_out_side.first1),
      .in_bit   (w0_out_bit),
      .in_side  (w0_out_side),
      .frame_w  (ew3_ff),
      .frame_h  (eh3_ff),
      .out_vld  (w1_out_vld),
      .out_bit  (w1_out_bit),
      .out_side (w1_out_side)
   );

   // result queue with credit count of words in flight
   assign q_push   = w1_out_vld && w1_out_side.emit;
   assign q_pop    = rsp_valid && !rsp_stall;
   assign pend_inc = step && emit;
   assign req_stall = pend_ff == cmc_pkg::PEND_W'(cmc_pkg::Q_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
         pend_ff  <= '0;
      end else begin
         if (q_push) begin
            q_wr_ff <= q_wr_ff + cmc_pkg::Q_AW'(1);
         end
         if (q_pop) begin
            q_rd_ff <= q_rd_ff + cmc_pkg::Q_AW'(1);
         end
         q_cnt_ff <= q_cnt_ff + cmc_pkg::PEND_W'(q_push) - cmc_pkg::PEND_W'(q_pop);
         pend_ff  <= pend_ff + cmc_pkg::PEND_W'(pend_inc) - cmc_pkg::PEND_W'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem_ff[q_wr_ff] <= '{closed: w1_out_bit, row: w1_out_side.row,
                                col: w1_out_side.col, last: w1_out_side.last};
      end
   end

   assign q_head         = q_mem_ff[q_rd_ff];
   assign rsp_valid      = q_cnt_ff != '0;
   assign rsp_closed_bit = q_head.closed;
   assign rsp_out_row    = q_head.row;
   assign rsp_out_column = q_head.col;
   assign rsp_frame_last = q_head.last;

   // checks
   `CMC_ASSERT_SAME(a_pend_bound, clock, reset, 1'b1, pend_ff <= cmc_pkg::PEND_W'(cmc_pkg::Q_DEPTH), "credit count above queue depth")
   `CMC_ASSERT_SAME(a_queue_in_credit, clock, reset, 1'b1, q_cnt_ff <= pend_ff, "queue holds more words than credited")
   `CMC_ASSERT_SAME(a_no_overflow, clock, reset, q_push, (q_cnt_ff != cmc_pkg::PEND_W'(cmc_pkg::Q_DEPTH)) || q_pop, "result queue overflow")
   `CMC_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && (t_ff == SW'(1)), "frame start did not arm the step counter")
   `CMC_ASSERT_NEXT(a_last_idle, clock, reset, step && emit && last, !busy_ff, "block still busy after last bit")

endmodule

// ----- test/cmc_checker.sv -----
// Checker for color_mask_closing: follows the word, result and register ports,
// predicts every closed-mask bit and compares it. Depends on cmc_pkg only.
module cmc_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_command,
   input  logic [cmc_pkg::CH_W-1:0]  req_blue,
   input  logic [cmc_pkg::CH_W-1:0]  req_green,
   input  logic [cmc_pkg::CH_W-1:0]  req_red,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_closed_bit,
   input  logic [cmc_pkg::OUT_W-1:0] rsp_out_row,
   input  logic [cmc_pkg::OUT_W-1:0] rsp_out_column,
   input  logic                      rsp_frame_last,
   input  logic                      csr_write,
   input  logic [cmc_pkg::IDX_W-1:0] csr_index,
   input  logic [cmc_pkg::DIM_W-1:0] csr_data,
   output int                        errors,
   output int                        pending,
   output int                        bits_seen,
   output int                        frames_seen
);
   import cmc_pkg::*;

   localparam int SLOTS = 2 * RADIUS + 2;

   typedef struct {
      logic             closed;
      logic [OUT_W-1:0] row;
      logic [OUT_W-1:0] col;
      logic             last;
   } mask_bit_type;

   mask_bit_type mask_expected[$];

   // thresholds and frame size as written
   logic [CH_W-1:0]  lo_ch[3];
   logic [CH_W-1:0]  hi_ch[3];
   logic [DIM_W-1:0] width_reg, height_reg;

   // line stores: one bit per ring slot per column
   logic [SLOTS-1:0] raw_store[MAX_WIDTH];
   logic [SLOTS-1:0] dil_store[MAX_WIDTH];
   int unsigned      fw, fh, steps;
   bit               busy;

   function automatic int unsigned clip_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   // ring slots of the rows inside the window and inside the frame
   function automatic logic [SLOTS-1:0] window_rows(int unsigned r);
      logic [SLOTS-1:0] m;
      int               y;
      m = '0;
      for (int dy = -RADIUS; dy <= RADIUS; dy++) begin
         y = int'(r) + dy;
         if (y >= 0 && y < int'(fh)) m[y % SLOTS] = 1'b1;
      end
      return m;
   endfunction

   function automatic logic dilate_hit(int unsigned r, int unsigned c);
      logic [SLOTS-1:0] m;
      int               x;
      m = window_rows(r);
      for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
         x = int'(c) + dx;
         if (x >= 0 && x < int'(fw) && (raw_store[x] & m) != '0) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic erode_keep(int unsigned r, int unsigned c);
      logic [SLOTS-1:0] m;
      int               x;
      m = window_rows(r);
      for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
         x = int'(c) + dx;
         if (x >= 0 && x < int'(fw) && (dil_store[x] & m) != m) return 1'b0;
      end
      return 1'b1;
   endfunction

   // one accepted word through the threshold, dilate and erode stages
   function automatic void closing_predict(logic cmd, logic [CH_W-1:0] b,
                                           logic [CH_W-1:0] g, logic [CH_W-1:0] r);
      int unsigned     n, lag, t, d, e, rr, cc;
      logic            hit;
      logic [CH_W-1:0] ch[3];
      mask_bit_type    mb;
      if (!busy) begin
         if (cmd == CMD_DRAIN) return;
         fw    = clip_size(width_reg, MAX_WIDTH);
         fh    = clip_size(height_reg, MAX_HEIGHT);
         steps = 0;
         busy  = 1;
      end
      n   = fw * fh;
      lag = RADIUS * fw + RADIUS;
      t   = steps;
      if (t < n) begin
         if (cmd == CMD_DRAIN) return;
         ch[0] = b; ch[1] = g; ch[2] = r;
         hit = 1'b1;
         for (int i = 0; i < 3; i++)
            if (ch[i] < lo_ch[i] || ch[i] > hi_ch[i]) hit = 1'b0;
         raw_store[t % fw][(t / fw) % SLOTS] = hit;
      end
      if (t >= lag && t - lag < n) begin
         d = t - lag;
         dil_store[d % fw][(d / fw) % SLOTS] = dilate_hit(d / fw, d % fw);
      end
      steps = t + 1;
      if (t >= 2 * lag && t - 2 * lag < n) begin
         e  = t - 2 * lag;
         rr = e / fw;
         cc = e % fw;
         mb.closed = dil_store[cc][rr % SLOTS] ? erode_keep(rr, cc) : 1'b0;
         mb.row    = rr[OUT_W-1:0];
         mb.col    = cc[OUT_W-1:0];
         mb.last   = (e == n - 1);
         mask_expected = {mask_expected, mb};
         if (mb.last) busy = 0;
      end
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   initial begin
      errors = 0; bits_seen = 0; frames_seen = 0; pending = 0;
   end

   // everything is sampled mid-cycle, where inputs and outputs are settled
   always @(negedge clock) begin
      mask_bit_type mb;
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            lo_ch[i] = '0;
            hi_ch[i] = '1;
         end
         width_reg  = RESET_WIDTH;
         height_reg = RESET_HEIGHT;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            raw_store[i] = '0;
            dil_store[i] = '0;
         end
         busy = 0;
         fw = 1; fh = 1; steps = 0;
         mask_expected.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_LOW_BLUE:     lo_ch[0]   = csr_data[CH_W-1:0];
               REG_LOW_GREEN:    lo_ch[1]   = csr_data[CH_W-1:0];
               REG_LOW_RED:      lo_ch[2]   = csr_data[CH_W-1:0];
               REG_HIGH_BLUE:    hi_ch[0]   = csr_data[CH_W-1:0];
               REG_HIGH_GREEN:   hi_ch[1]   = csr_data[CH_W-1:0];
               REG_HIGH_RED:     hi_ch[2]   = csr_data[CH_W-1:0];
               REG_FRAME_WIDTH:  width_reg  = csr_data;
               REG_FRAME_HEIGHT: height_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            closing_predict(req_command, req_blue, req_green, req_red);
         if (rsp_valid && !rsp_stall) begin
            bits_seen++;
            if (rsp_frame_last) frames_seen++;
            if (mask_expected.size() == 0) begin
               report("unexpected result word, row", rsp_out_row, -1);
            end else begin
               mb = mask_expected.pop_front();
               if (rsp_closed_bit !== mb.closed) report("closed_bit", rsp_closed_bit, mb.closed);
               if (rsp_out_row !== mb.row)       report("out_row", rsp_out_row, mb.row);
               if (rsp_out_column !== mb.col)    report("out_column", rsp_out_column, mb.col);
               if (rsp_frame_last !== mb.last)   report("frame_last", rsp_frame_last, mb.last);
            end
         end
      end
      pending = mask_expected.size();
   end

endmodule

// ----- test/tb_color_mask_closing.sv -----
// Top of the color_mask_closing testbench: clock, reset, frame stimulus with
// idle and stall phases, watchdog and verdict. Depends on cmc_pkg and cmc_checker.
module tb_color_mask_closing;
   import cmc_pkg::*;

   localparam int WATCH_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;

   logic              clock, reset;
   logic              req_valid, req_stall, req_command;
   logic [CH_W-1:0]   req_blue, req_green, req_red;
   logic              rsp_valid, rsp_stall, rsp_closed_bit, rsp_frame_last;
   logic [OUT_W-1:0]  rsp_out_row, rsp_out_column;
   logic              csr_write;
   logic [IDX_W-1:0]  csr_index;
   logic [DIM_W-1:0]  csr_data;

   int errors, pending, bits_seen, frames_seen;
   int send_idle_pct, recv_stall_pct, words_sent, idle_cycles, hold_left;
   bit hold_go, hold_taken;

   // frame settings for the next frame
   logic [CH_W-1:0] lo_set[3], hi_set[3];

   color_mask_closing i_dut (.*);

   cmc_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog: cycles in which no word moves on either channel
   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send_word(logic cmd, logic [CH_W-1:0] b, logic [CH_W-1:0] g,
                            logic [CH_W-1:0] r);
      bit stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_blue    <= b;
      req_green   <= g;
      req_red     <= r;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      words_sent++;
   endtask

   task automatic send_rand(logic cmd);
      send_word(cmd, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
   endtask

   // a pixel that hits the color box with the given chance in percent
   task automatic send_pixel(int hit_pct);
      logic [CH_W-1:0] ch[3];
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(99) < hit_pct && lo_set[i] <= hi_set[i])
            ch[i] = CH_W'($urandom_range(hi_set[i], lo_set[i]));
         else
            ch[i] = CH_W'($urandom);
      end
      send_word(CMD_PIXEL, ch[0], ch[1], ch[2]);
   endtask

   // wait for all results, then for the pipeline to settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // all eight registers, written while idle
   task automatic write_regs(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      logic [IDX_W-1:0] idx;
      logic [DIM_W-1:0] val;
      req_valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
         idx = IDX_W'(i);
         case (idx)
            REG_LOW_BLUE:     val = lo_set[0];
            REG_LOW_GREEN:    val = lo_set[1];
            REG_LOW_RED:      val = lo_set[2];
            REG_HIGH_BLUE:    val = hi_set[0];
            REG_HIGH_GREEN:   val = hi_set[1];
            REG_HIGH_RED:     val = hi_set[2];
            REG_FRAME_WIDTH:  val = w;
            default:          val = h;
         endcase
         csr_write <= 1'b1;
         csr_index <= idx;
         csr_data  <= val;
         @(posedge clock);
      end
      csr_write <= 1'b0;
   endtask

   task automatic random_box();
      logic [CH_W-1:0] a, b;
      for (int i = 0; i < 3; i++) begin
         a = CH_W'($urandom);
         b = CH_W'($urandom);
         if ($urandom_range(9) == 0) begin
            lo_set[i] = a; hi_set[i] = b;            // may be empty
         end else begin
            lo_set[i] = (a < b) ? a : b;
            hi_set[i] = (a < b) ? b : a;
         end
      end
   endtask

   // one frame: pixels with stray early drains, then the drain tail
   task automatic run_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int hit_pct,
                            bit noisy);
      int unsigned fw, fh, n, tail;
      fw   = (w == 0) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
      fh   = (h == 0) ? 1 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
      n    = fw * fh;
      tail = 2 * (RADIUS * fw + RADIUS);
      write_regs(w, h);
      if (noisy && $urandom_range(1)) send_rand(CMD_DRAIN);   // drain while idle
      for (int unsigned i = 0; i < n; i++) begin
         if (noisy && i != 0 && $urandom_range(19) == 0) send_rand(CMD_DRAIN);
         send_pixel(hit_pct);
      end
      // a pixel after the frame is complete acts as a drain
      for (int unsigned i = 0; i < tail; i++)
         send_rand((noisy && $urandom_range(3) == 0) ? CMD_PIXEL : CMD_DRAIN);
      if (noisy && $urandom_range(1)) send_rand(CMD_DRAIN);   // drain once idle again
      wait_drained();
   endtask

   initial begin
      int phase;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = CMD_PIXEL;
      req_blue    = '0;
      req_green   = '0;
      req_red     = '0;
      csr_write   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      words_sent     = 0;
      hold_go        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: drain while idle, zero sizes, exact-value box, empty box
      send_word(CMD_DRAIN, 8'hFF, 8'h00, 8'hFF);
      for (int i = 0; i < 3; i++) begin lo_set[i] = 8'h00; hi_set[i] = 8'hFF; end
      run_frame(11'd0, 11'd0, 100, 1'b0);
      for (int i = 0; i < 3; i++) begin lo_set[i] = 8'd128; hi_set[i] = 8'd128; end
      write_regs(11'd3, 11'd2);
      send_word(CMD_PIXEL, 8'd128, 8'd128, 8'd128);
      send_word(CMD_DRAIN, 8'd0, 8'd0, 8'd0);          // early drain, ignored
      send_word(CMD_PIXEL, 8'd127, 8'd128, 8'd128);
      send_word(CMD_PIXEL, 8'd128, 8'd129, 8'd128);
      send_word(CMD_PIXEL, 8'd128, 8'd128, 8'd127);
      send_word(CMD_PIXEL, 8'd255, 8'd0, 8'd255);
      send_word(CMD_PIXEL, 8'd128, 8'd128, 8'd128);
      for (int i = 0; i < 2 * (RADIUS * 3 + RADIUS); i++)
         send_rand(i % 2 ? CMD_PIXEL : CMD_DRAIN);
      wait_drained();
      for (int i = 0; i < 3; i++) begin lo_set[i] = 8'd200; hi_set[i] = 8'd10; end
      run_frame(11'd4, 11'd4, 50, 1'b0);

      // random frames, cycling through the idle and stall phases
      phase = 0;
      while (words_sent < 700 || phase < 4) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         random_box();
         if (phase == 0) begin
            // long receiver hold while pixels keep coming, so the block backs up
            hold_go <= 1'b1;
            run_frame(11'd12, 11'd12, 60, 1'b1);
         end else begin
            run_frame(DIM_W'($urandom_range(12, 1)), DIM_W'($urandom_range(12, 1)),
                      $urandom_range(95, 5), 1'b1);
         end
         phase++;
      end

      // a tall frame one pixel wide
      send_idle_pct  = 0;
      recv_stall_pct = 10;
      random_box();
      run_frame(11'd1, 11'd60, 70, 1'b1);

      repeat (30) @(posedge clock);
      $display("covered %0d input words, %0d mask bits in %0d frames",
               words_sent, bits_seen, frames_seen);
      $display("zero sizes, exact and empty color boxes, frames up to 12x12 and 1x60,");
      $display("with idle, stall and long hold phases");
      if (errors == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
